@@ sv/crtcpp_pkg.sv @@
// crtcpp_pkg: shared constants, mode codes and pixel spread tables for the
// CRTC pixel packer. No dependencies.
`timescale 1ns / 1ps

package crtcpp_pkg;

    localparam int PIXEL_W   = 4;
    localparam int SLOT_W    = 3;
    localparam int COL_W     = 8;
    localparam int RASTER_W  = 3;
    localparam int START_W   = 14;
    localparam int ADDR_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 14;

    // video mode codes
    localparam logic [1:0] MODE_4BIT      = 2'd0;
    localparam logic [1:0] MODE_2BIT      = 2'd1;
    localparam logic [1:0] MODE_1BIT      = 2'd2;
    localparam logic [1:0] MODE_2BIT_HALF = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIDEO_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_PER_LINE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RASTER_LINES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS  = 2'd3;

    // reset values
    localparam logic [1:0]          RST_VIDEO_MODE     = MODE_2BIT;
    localparam logic [COL_W-1:0]    RST_CHARS_PER_LINE = 8'd40;
    localparam logic [RASTER_W-1:0] RST_RASTER_LINES   = 3'd7;
    localparam logic [START_W-1:0]  RST_START_ADDRESS  = 14'd12288;

    localparam logic [7:0] SPREAD4 [16] = '{
        8'd0, 8'd64, 8'd4, 8'd68, 8'd16, 8'd80, 8'd20, 8'd84,
        8'd1, 8'd65, 8'd5, 8'd69, 8'd17, 8'd81, 8'd21, 8'd85
    };

    localparam logic [7:0] SPREAD2 [4] = '{8'd0, 8'd16, 8'd1, 8'd17};

endpackage

@@ sv/crtc_pixel_packer.sv @@
// crtc_pixel_packer: top level. Packs pixels into screen bytes, tracks the
// CRTC position and reports the address range per frame.
// Depends on crtcpp_pkg and crtcpp_byte_pack.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid, in_ready, pixel, frame_last     | in
//   output  | out_valid, out_ready, address, data_byte, | out
//           | frame_done, lowest_address, highest_address|
//   config  | cfg_write, cfg_index, cfg_data            | in
//
// One item per clock: the pack, address and min/max update all complete in
// the cycle an item is taken, and a completed byte lands in the output register.
// The next item is taken while that register is empty or being drained.
// Reset is asynchronous, active low, and loads the register defaults; no
// clearing pass is needed.
`timescale 1ns / 1ps

module crtc_pixel_packer (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_write,
    input  logic [crtcpp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [crtcpp_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [crtcpp_pkg::PIXEL_W-1:0]        pixel,
    input  logic                                  frame_last,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [crtcpp_pkg::ADDR_W-1:0]         address,
    output logic [7:0]                            data_byte,
    output logic                                  frame_done,
    output logic [crtcpp_pkg::ADDR_W-1:0]         lowest_address,
    output logic [crtcpp_pkg::ADDR_W-1:0]         highest_address
);

    localparam int AW = crtcpp_pkg::ADDR_W;

    // configuration
    logic [1:0]                          video_mode_reg;
    logic [crtcpp_pkg::COL_W-1:0]        chars_per_line_reg;
    logic [crtcpp_pkg::RASTER_W-1:0]     raster_lines_reg;
    logic [crtcpp_pkg::START_W-1:0]      start_address_reg;

    // position and packing state
    logic [crtcpp_pkg::SLOT_W-1:0]       pixel_slot_reg, pixel_slot_next;
    logic [7:0]                          acc_reg, acc_next;
    logic                                byte_half_reg, byte_half_next;
    logic [crtcpp_pkg::COL_W-1:0]        char_column_reg, char_column_next;
    logic [crtcpp_pkg::RASTER_W-1:0]     raster_reg, raster_next;
    logic [AW-1:0]                       row_base_reg, row_base_next;
    logic [AW-1:0]                       min_seen_reg, min_seen_next;
    logic [AW-1:0]                       max_seen_reg, max_seen_next;
    logic                                frame_open_reg, frame_open_next;

    // result register
    logic                                out_valid_reg, out_valid_next;
    logic [AW-1:0]                       address_reg;
    logic [7:0]                          data_byte_reg;
    logic                                frame_done_reg;
    logic [AW-1:0]                       lowest_reg;
    logic [AW-1:0]                       highest_reg;

    logic          in_fire;
    logic          emit;
    logic [7:0]    acc_merged;
    logic          full;
    logic [AW-1:0] base_eff, min_eff, max_eff;
    logic [AW-1:0] ma;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] min_upd, max_upd;
    logic [crtcpp_pkg::COL_W-1:0] col_inc;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    crtcpp_byte_pack u_pack (
        .video_mode (video_mode_reg),
        .pixel      (pixel),
        .slot       (pixel_slot_reg),
        .acc        (acc_reg),
        .acc_merged (acc_merged),
        .full       (full)
    );

    // first pixel of a frame starts from the display start and an empty range
    assign base_eff = frame_open_reg ? row_base_reg : {2'b00, start_address_reg};
    assign min_eff  = frame_open_reg ? min_seen_reg : {AW{1'b1}};
    assign max_eff  = frame_open_reg ? max_seen_reg : {AW{1'b0}};

    assign ma       = base_eff + {{(AW-crtcpp_pkg::COL_W){1'b0}}, char_column_reg};
    assign cur_addr = {ma[13:12], raster_reg, ma[9:0], byte_half_reg};
    assign min_upd  = (cur_addr < min_eff) ? cur_addr : min_eff;
    assign max_upd  = (cur_addr > max_eff) ? cur_addr : max_eff;
    assign emit     = full || frame_last;
    assign col_inc  = char_column_reg + 8'd1;

    always_comb
    begin
        pixel_slot_next  = pixel_slot_reg;
        acc_next         = acc_reg;
        byte_half_next   = byte_half_reg;
        char_column_next = char_column_reg;
        raster_next      = raster_reg;
        row_base_next    = row_base_reg;
        min_seen_next    = min_seen_reg;
        max_seen_next    = max_seen_reg;
        frame_open_next  = frame_open_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        if (in_fire)
        begin
            row_base_next   = base_eff;
            min_seen_next   = min_eff;
            max_seen_next   = max_eff;
            frame_open_next = 1'b1;
            acc_next        = acc_merged;
            pixel_slot_next = pixel_slot_reg + 3'd1;

            if (emit)
            begin
                out_valid_next = 1'b1;
                min_seen_next  = min_upd;
                max_seen_next  = max_upd;
                if (frame_last)
                begin
                    // close the frame and drop back to the origin
                    pixel_slot_next  = 3'd0;
                    acc_next         = 8'd0;
                    byte_half_next   = 1'b0;
                    char_column_next = 8'd0;
                    raster_next      = 3'd0;
                    frame_open_next  = 1'b0;
                end
                else
                begin
                    pixel_slot_next = 3'd0;
                    acc_next        = 8'd0;
                    if (!byte_half_reg)
                        byte_half_next = 1'b1;
                    else
                    begin
                        byte_half_next   = 1'b0;
                        char_column_next = col_inc;
                        if (col_inc >= chars_per_line_reg || col_inc == 8'd0)
                        begin
                            char_column_next = 8'd0;
                            if (raster_reg >= raster_lines_reg)
                            begin
                                raster_next   = 3'd0;
                                row_base_next = base_eff
                                    + {{(AW-crtcpp_pkg::COL_W){1'b0}}, chars_per_line_reg};
                            end
                            else
                                raster_next = raster_reg + 3'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_mode_reg     <= crtcpp_pkg::RST_VIDEO_MODE;
            chars_per_line_reg <= crtcpp_pkg::RST_CHARS_PER_LINE;
            raster_lines_reg   <= crtcpp_pkg::RST_RASTER_LINES;
            start_address_reg  <= crtcpp_pkg::RST_START_ADDRESS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                crtcpp_pkg::REG_VIDEO_MODE:     video_mode_reg     <= cfg_data[1:0];
                crtcpp_pkg::REG_CHARS_PER_LINE: chars_per_line_reg <= cfg_data[7:0];
                crtcpp_pkg::REG_RASTER_LINES:   raster_lines_reg   <= cfg_data[2:0];
                crtcpp_pkg::REG_START_ADDRESS:  start_address_reg  <= cfg_data;
                default:                        video_mode_reg     <= video_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_slot_reg  <= '0;
            acc_reg         <= '0;
            byte_half_reg   <= 1'b0;
            char_column_reg <= '0;
            raster_reg      <= '0;
            row_base_reg    <= {2'b00, crtcpp_pkg::RST_START_ADDRESS};
            min_seen_reg    <= {AW{1'b1}};
            max_seen_reg    <= '0;
            frame_open_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pixel_slot_reg  <= pixel_slot_next;
            acc_reg         <= acc_next;
            byte_half_reg   <= byte_half_next;
            char_column_reg <= char_column_next;
            raster_reg      <= raster_next;
            row_base_reg    <= row_base_next;
            min_seen_reg    <= min_seen_next;
            max_seen_reg    <= max_seen_next;
            frame_open_reg  <= frame_open_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload: load only when a byte is emitted
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            address_reg    <= cur_addr;
            data_byte_reg  <= acc_merged;
            frame_done_reg <= frame_last;
            lowest_reg     <= frame_last ? min_upd : {AW{1'b0}};
            highest_reg    <= frame_last ? max_upd : {AW{1'b0}};
        end
    end

    assign out_valid       = out_valid_reg;
    assign address         = address_reg;
    assign data_byte       = data_byte_reg;
    assign frame_done      = frame_done_reg;
    assign lowest_address  = lowest_reg;
    assign highest_address = highest_reg;

    a_range_holds_address: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |->
            lowest_address <= address && address <= highest_address)
        else $error("frame range does not cover the last address");

    a_range_zero_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |->
            lowest_address == 16'd0 && highest_address == 16'd0)
        else $error("address range reported outside frame end");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && frame_last |=>
            pixel_slot_reg == 3'd0 && !byte_half_reg && char_column_reg == 8'd0
            && raster_reg == 3'd0 && !frame_open_reg && out_valid_reg)
        else $error("position not cleared after the last pixel");

endmodule

@@ sv/crtcpp_byte_pack.sv @@
// crtcpp_byte_pack: merges one pixel into the partial screen byte in the
// interleaved bit order of the video mode. Uses crtcpp_pkg.
`timescale 1ns / 1ps

module crtcpp_byte_pack (
    input  logic [1:0]                     video_mode,
    input  logic [crtcpp_pkg::PIXEL_W-1:0] pixel,
    input  logic [crtcpp_pkg::SLOT_W-1:0]  slot,
    input  logic [7:0]                     acc,
    output logic [7:0]                     acc_merged,
    output logic                           full
);

    logic [7:0] bits;
    logic [3:0] ppb;
    logic [3:0] slot_plus;

    always_comb
    begin
        bits = 8'd0;
        ppb  = 4'd2;
        case (video_mode)
            crtcpp_pkg::MODE_4BIT:
            begin
                ppb = 4'd2;
                if (slot == 3'd0)
                    bits = crtcpp_pkg::SPREAD4[pixel] << 1;
                else if (slot == 3'd1)
                    bits = crtcpp_pkg::SPREAD4[pixel];
            end
            crtcpp_pkg::MODE_1BIT:
            begin
                ppb  = 4'd8;
                bits = {7'd0, pixel[0]} << (3'd7 - slot);
            end
            crtcpp_pkg::MODE_2BIT, crtcpp_pkg::MODE_2BIT_HALF:
            begin
                ppb = (video_mode == crtcpp_pkg::MODE_2BIT) ? 4'd4 : 4'd2;
                // half mode shares the spread, so its pixels sit in the upper slots
                if (slot < 3'd4)
                    bits = crtcpp_pkg::SPREAD2[pixel[1:0]] << (2'd3 - slot[1:0]);
            end
            default:
            begin
                bits = 8'd0;
                ppb  = 4'd2;
            end
        endcase
    end

    assign slot_plus  = {1'b0, slot} + 4'd1;
    assign full       = (slot_plus >= ppb);
    assign acc_merged = acc | bits;

endmodule

@@ test/tb_crtc_pixel_packer.sv @@
// tb_crtc_pixel_packer: self-checking testbench for the CRTC pixel packer.
// Holds a screen byte tracker class that predicts each packed byte and address.
// Depends on crtcpp_pkg and crtc_pixel_packer.
`timescale 1ns / 1ps

typedef struct packed {
    logic [crtcpp_pkg::ADDR_W-1:0] address;
    logic [7:0]                    data_byte;
    logic                          frame_done;
    logic [crtcpp_pkg::ADDR_W-1:0] lowest_address;
    logic [crtcpp_pkg::ADDR_W-1:0] highest_address;
} screen_write_t;

class screen_byte_tracker;
    logic [1:0]                      video_mode;
    logic [crtcpp_pkg::COL_W-1:0]    chars_per_line;
    logic [crtcpp_pkg::RASTER_W-1:0] raster_lines_m1;
    logic [crtcpp_pkg::START_W-1:0]  start_address;

    logic [crtcpp_pkg::SLOT_W-1:0]   pixel_slot;
    logic [7:0]                      byte_acc;
    logic                            byte_half;
    logic [crtcpp_pkg::COL_W-1:0]    char_column;
    logic [crtcpp_pkg::RASTER_W-1:0] raster_in_char;
    logic [crtcpp_pkg::ADDR_W-1:0]   row_base;
    logic [crtcpp_pkg::ADDR_W-1:0]   min_seen;
    logic [crtcpp_pkg::ADDR_W-1:0]   max_seen;
    bit                              frame_open;

    screen_write_t       pending_writes[$];
    int                  error_count;

    function new();
        video_mode      = crtcpp_pkg::RST_VIDEO_MODE;
        chars_per_line  = crtcpp_pkg::RST_CHARS_PER_LINE;
        raster_lines_m1 = crtcpp_pkg::RST_RASTER_LINES;
        start_address   = crtcpp_pkg::RST_START_ADDRESS;
        pixel_slot      = '0;
        byte_acc        = '0;
        byte_half       = 1'b0;
        char_column     = '0;
        raster_in_char  = '0;
        row_base        = {2'b00, start_address};
        min_seen        = '1;
        max_seen        = '0;
        frame_open      = 1'b0;
        error_count     = 0;
    endfunction

    function void set_register(logic [crtcpp_pkg::CFG_IDX_W-1:0] idx,
                               logic [crtcpp_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            crtcpp_pkg::REG_VIDEO_MODE:     video_mode      = value[1:0];
            crtcpp_pkg::REG_CHARS_PER_LINE: chars_per_line  = value[crtcpp_pkg::COL_W-1:0];
            crtcpp_pkg::REG_RASTER_LINES:   raster_lines_m1 = value[crtcpp_pkg::RASTER_W-1:0];
            crtcpp_pkg::REG_START_ADDRESS:  start_address   = value[crtcpp_pkg::START_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return pending_writes.size();
    endfunction

    // Pack one accepted pixel; queue the screen write it completes, if any.
    function void take_pixel(logic [crtcpp_pkg::PIXEL_W-1:0] pix, logic last);
        int            slot;
        int            slots_per_byte;
        int            bits;
        bit            full;
        logic [15:0]   ma;
        screen_write_t w;
        slot = pixel_slot;
        bits = 0;
        if (!frame_open) begin
            row_base   = {2'b00, start_address};
            min_seen   = '1;
            max_seen   = '0;
            frame_open = 1'b1;
        end
        case (video_mode)
            crtcpp_pkg::MODE_4BIT: begin
                slots_per_byte = 2;
                if (slot < 2)
                    bits = int'(crtcpp_pkg::SPREAD4[pix]) << (1 - slot);
            end
            crtcpp_pkg::MODE_1BIT: begin
                slots_per_byte = 8;
                bits = int'(pix[0]) << (7 - slot);
            end
            default: begin
                // half mode keeps the upper two slots of the 2-bit layout
                slots_per_byte = (video_mode == crtcpp_pkg::MODE_2BIT) ? 4 : 2;
                if (slot < 4)
                    bits = int'(crtcpp_pkg::SPREAD2[pix[1:0]]) << (3 - slot);
            end
        endcase
        byte_acc   = byte_acc | bits[7:0];
        full       = (slot + 1) >= slots_per_byte;
        pixel_slot = pixel_slot + 3'd1;
        if (!full && !last)
            return;

        ma = row_base + {8'd0, char_column};
        w.address = {ma[13:12], raster_in_char, ma[9:0], byte_half};
        if (w.address < min_seen)
            min_seen = w.address;
        if (w.address > max_seen)
            max_seen = w.address;
        w.data_byte       = byte_acc;
        w.frame_done      = last;
        w.lowest_address  = last ? min_seen : '0;
        w.highest_address = last ? max_seen : '0;
        pending_writes.push_back(w);

        pixel_slot = '0;
        byte_acc   = '0;
        if (last) begin
            byte_half      = 1'b0;
            char_column    = '0;
            raster_in_char = '0;
            frame_open     = 1'b0;
        end
        else if (!byte_half) begin
            byte_half = 1'b1;
        end
        else begin
            byte_half   = 1'b0;
            char_column = char_column + 8'd1;
            // a zero column count behaves as one column per line
            if (char_column >= chars_per_line || char_column == '0) begin
                char_column = '0;
                if (raster_in_char >= raster_lines_m1) begin
                    raster_in_char = '0;
                    row_base       = row_base + {8'd0, chars_per_line};
                end
                else begin
                    raster_in_char = raster_in_char + 3'd1;
                end
            end
        end
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task check_screen_write(screen_write_t got);
        screen_write_t want;
        if (pending_writes.size() == 0) begin
            report($sformatf("unexpected screen write to %h data %h", got.address,
                             got.data_byte));
            return;
        end
        want = pending_writes.pop_front();
        if (got.address != want.address)
            report($sformatf("address %h, want %h", got.address, want.address));
        if (got.data_byte != want.data_byte)
            report($sformatf("data_byte %h at %h, want %h", got.data_byte, want.address,
                             want.data_byte));
        if (got.frame_done != want.frame_done)
            report($sformatf("frame_done %b at %h, want %b", got.frame_done, want.address,
                             want.frame_done));
        if (got.lowest_address != want.lowest_address)
            report($sformatf("lowest_address %h, want %h", got.lowest_address,
                             want.lowest_address));
        if (got.highest_address != want.highest_address)
            report($sformatf("highest_address %h, want %h", got.highest_address,
                             want.highest_address));
    endtask
endclass

module tb_crtc_pixel_packer;

    localparam int RANDOM_PIXELS = 500;
    localparam int CYCLE_LIMIT   = 200000;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_write = 1'b0;
    logic [crtcpp_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [crtcpp_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    logic                                  in_valid = 1'b0;
    logic                                  in_ready;
    logic [crtcpp_pkg::PIXEL_W-1:0]        pixel = '0;
    logic                                  frame_last = 1'b0;
    logic                                  out_valid;
    logic                                  out_ready = 1'b0;
    logic [crtcpp_pkg::ADDR_W-1:0]         address;
    logic [7:0]                            data_byte;
    logic                                  frame_done;
    logic [crtcpp_pkg::ADDR_W-1:0]         lowest_address;
    logic [crtcpp_pkg::ADDR_W-1:0]         highest_address;

    screen_byte_tracker tracker;
    bit                 sender_idles = 1'b1;
    bit                 receiver_idles = 1'b1;
    int                 long_hold_cycles = 0;
    int                 cycle_count = 0;

    crtc_pixel_packer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel           (pixel),
        .frame_last      (frame_last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .address         (address),
        .data_byte       (data_byte),
        .frame_done      (frame_done),
        .lowest_address  (lowest_address),
        .highest_address (highest_address)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic int draw_gap(bit idles);
        return idles ? int'($urandom_range(0, 6)) : 0;
    endfunction

    task automatic send_pixel(logic [crtcpp_pkg::PIXEL_W-1:0] pix, logic last);
        int gap;
        gap = draw_gap(sender_idles);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        pixel      <= pix;
        frame_last <= last;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and hold until every expected screen write has come out.
    task automatic settle_output();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(logic [crtcpp_pkg::CFG_IDX_W-1:0] idx,
                                  logic [crtcpp_pkg::CFG_DATA_W-1:0] value);
        settle_output();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        tracker.set_register(idx, value);
    endtask

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Sample both channels at the rising edge; inputs are noted before results.
    initial begin
        screen_write_t got;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (in_valid && in_ready)
                tracker.take_pixel(pixel, frame_last);
            if (out_valid && out_ready) begin
                got.address         = address;
                got.data_byte       = data_byte;
                got.frame_done      = frame_done;
                got.lowest_address  = lowest_address;
                got.highest_address = highest_address;
                tracker.check_screen_write(got);
            end
        end
    end

    // Receiver: may stall before each item, or once for a long stretch on request.
    initial begin
        int gap;
        wait (rst_n === 1'b1);
        forever begin
            if (long_hold_cycles > 0) begin
                gap = long_hold_cycles;
                long_hold_cycles = 0;
            end
            else begin
                gap = draw_gap(receiver_idles);
            end
            if (gap > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        int                                sent;
        int                                frame_len;
        int                                frame_pos;
        int                                chunk;
        logic                              last;
        logic [crtcpp_pkg::CFG_DATA_W-1:0] value;

        tracker = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings; a frame that ends mid byte flushes with zero pixels
        send_pixel(4'd3, 1'b0);
        send_pixel(4'd0, 1'b0);
        send_pixel(4'd1, 1'b0);
        send_pixel(4'd2, 1'b0);
        send_pixel(4'd15, 1'b1);

        // One column, one raster: the row base steps past the 14-bit start range
        write_register(crtcpp_pkg::REG_VIDEO_MODE, {12'd0, crtcpp_pkg::MODE_4BIT});
        write_register(crtcpp_pkg::REG_CHARS_PER_LINE, 14'd1);
        write_register(crtcpp_pkg::REG_RASTER_LINES, 14'd0);
        write_register(crtcpp_pkg::REG_START_ADDRESS, 14'd16383);
        send_pixel(4'd15, 1'b0);
        send_pixel(4'd0, 1'b0);
        send_pixel(4'd0, 1'b0);
        send_pixel(4'd15, 1'b0);
        send_pixel(4'd5, 1'b0);
        send_pixel(4'd10, 1'b1);

        // Zero columns per line, then a mode change with a byte partly filled
        write_register(crtcpp_pkg::REG_VIDEO_MODE, {12'd0, crtcpp_pkg::MODE_1BIT});
        write_register(crtcpp_pkg::REG_CHARS_PER_LINE, 14'd0);
        write_register(crtcpp_pkg::REG_RASTER_LINES, 14'd7);
        send_pixel(4'd15, 1'b0);
        send_pixel(4'd0, 1'b0);
        send_pixel(4'd1, 1'b0);
        send_pixel(4'd14, 1'b0);
        send_pixel(4'd1, 1'b0);
        write_register(crtcpp_pkg::REG_VIDEO_MODE, {12'd0, crtcpp_pkg::MODE_2BIT_HALF});
        send_pixel(4'd14, 1'b0);
        send_pixel(4'd3, 1'b0);
        send_pixel(4'd2, 1'b1);

        sent      = 0;
        frame_pos = 0;
        frame_len = $urandom_range(1, 40);
        for (int phase = 0; sent < RANDOM_PIXELS; phase++) begin
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);

            // registers change between phases, usually in mid frame
            if ($urandom_range(0, 2) == 0)
                write_register(crtcpp_pkg::REG_VIDEO_MODE, 14'($urandom_range(0, 3)));
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0:       value = 14'd0;
                    1:       value = 14'd1;
                    2:       value = 14'd255;
                    default: value = 14'($urandom_range(1, 6));
                endcase
                write_register(crtcpp_pkg::REG_CHARS_PER_LINE, value);
            end
            if ($urandom_range(0, 2) == 0)
                write_register(crtcpp_pkg::REG_RASTER_LINES, 14'($urandom_range(0, 7)));
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0:       value = 14'd0;
                    1:       value = 14'd16383;
                    default: value = 14'($urandom_range(0, 16383));
                endcase
                write_register(crtcpp_pkg::REG_START_ADDRESS, value);
            end

            if (phase == 2)
                long_hold_cycles = 200;
            if (phase == 5)
                settle_output();

            // keep offering through the long hold so the block fills up
            chunk = (phase == 2) ? 40 : $urandom_range(8, 40);
            repeat (chunk) begin
                last = (frame_pos + 1 >= frame_len);
                send_pixel(4'($urandom_range(0, 15)), last);
                sent++;
                frame_pos++;
                if (last) begin
                    frame_pos = 0;
                    frame_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 80);
                end
            end
        end

        settle_output();
        repeat (8) @(posedge clk);
        if (tracker.error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/crtcpp_pkg.sv
sv/crtcpp_byte_pack.sv
sv/crtc_pixel_packer.sv
test/tb_crtc_pixel_packer.sv
